// ===== hdl/trsi_pkg.sv =====
// Shared widths, constants and types for the tetrahedron rest-shape inverse.
`default_nettype none
package trsi_pkg;
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int OW          = 32;
  localparam int EW          = COORD_WIDTH + 1;
  localparam int PW          = 2 * EW;
  localparam int AW          = PW + 1;
  localparam int LO_B        = EW + 1;
  localparam int PLW         = EW + LO_B + 1;
  localparam int DTW         = 3 * EW + 2;
  localparam int NW          = DTW + 1;
  localparam int QB          = OW + 1;
  localparam int DIV_LAT     = QB + 2;
  localparam int PRE         = 7;
  localparam int NDIV        = 9;
  localparam int VOL_RSH     = 2 * FRAC_BITS + 1;
  localparam int VOL_SH      = OW + 2;

  // The volume is (|det| + 3 * 2^(2F)) / (6 * 2^(2F)): a shift, then a divide by three.
  localparam logic [NW-1:0] VOL_BIAS  = NW'(3) << (2 * FRAC_BITS);
  localparam logic [NW-1:0] VOL_SAT   = NW'(3) << (OW - 1);
  localparam logic [QB-1:0] VOL_RECIP = QB'(33'h1_5555_5556);
  localparam logic [QB-1:0] POS_LIM = QB'(33'h0_7FFF_FFFF);
  localparam logic [QB-1:0] NEG_LIM = QB'(33'h0_8000_0000);
  localparam logic [OW-1:0] OUT_MAX = 32'h7FFF_FFFF;
  localparam logic [OW-1:0] OUT_MIN = 32'h8000_0000;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [EW-1:0]          edge_t;
  typedef logic signed [PW-1:0]          prod_t;
  typedef logic signed [AW-1:0]          adj_t;
  typedef logic signed [PLW-1:0]         plo_t;
  typedef logic signed [DTW-1:0]         det_t;
  typedef logic [NW-1:0]                 mag_t;
  typedef logic signed [OW-1:0]          res_t;
endpackage
`default_nettype wire

// ===== hdl/tet_rest_shape_inverse.sv =====
// Top level: tetrahedron edge matrix inverse and signed volume, fully pipelined.
//
//   channel | direction | ports                                   | handshake
//   in      | input     | in_v0_x .. in_v3_z                      | in_valid / in_ready
//   out     | output    | out_volume, out_inv_r0c0 .. r2c2, sing. | out_valid / out_ready
//
// One tetrahedron may be accepted every cycle while the output is not stalled; the
// pipeline has seven arithmetic stages, a 35-stage divider and one output register.
// The per-bit divider stages set the depth; nine dividers run side by side,
// and the volume takes a reciprocal multiply and a matching delay line.
// Reset clears only the valid pipeline; there is no clearing pass.
// A stalled output holds every stage, so nothing is lost or repeated.
`default_nettype none
module tet_rest_shape_inverse (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [trsi_pkg::COORD_WIDTH-1:0] in_v0_x,
  input  logic signed [trsi_pkg::COORD_WIDTH-1:0] in_v0_y,
  input  logic signed [trsi_pkg::COORD_WIDTH-1:0] in_v0_z,
  input  logic signed [trsi_pkg::COORD_WIDTH-1:0] in_v1_x,
  input  logic signed [trsi_pkg::COORD_WIDTH-1:0] in_v1_y,
  input  logic signed [trsi_pkg::COORD_WIDTH-1:0] in_v1_z,
  input  logic signed [trsi_pkg::COORD_WIDTH-1:0] in_v2_x,
  input  logic signed [trsi_pkg::COORD_WIDTH-1:0] in_v2_y,
  input  logic signed [trsi_pkg::COORD_WIDTH-1:0] in_v2_z,
  input  logic signed [trsi_pkg::COORD_WIDTH-1:0] in_v3_x,
  input  logic signed [trsi_pkg::COORD_WIDTH-1:0] in_v3_y,
  input  logic signed [trsi_pkg::COORD_WIDTH-1:0] in_v3_z,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [trsi_pkg::OW-1:0] out_volume,
  output logic signed [trsi_pkg::OW-1:0] out_inv_r0c0,
  output logic signed [trsi_pkg::OW-1:0] out_inv_r0c1,
  output logic signed [trsi_pkg::OW-1:0] out_inv_r0c2,
  output logic signed [trsi_pkg::OW-1:0] out_inv_r1c0,
  output logic signed [trsi_pkg::OW-1:0] out_inv_r1c1,
  output logic signed [trsi_pkg::OW-1:0] out_inv_r1c2,
  output logic signed [trsi_pkg::OW-1:0] out_inv_r2c0,
  output logic signed [trsi_pkg::OW-1:0] out_inv_r2c1,
  output logic signed [trsi_pkg::OW-1:0] out_inv_r2c2,
  output logic out_singular
);
  import trsi_pkg::*;

  localparam int VL = PRE + DIV_LAT;

  logic          en;
  logic [VL-1:0] v_r;
  logic          out_valid_r;

  coord_t p [4][3];
  edge_t  m1_r  [3][3];
  prod_t  pa2_r [3][3];
  prod_t  pb2_r [3][3];
  edge_t  r02_r [3];
  adj_t   adj3_r [3][3];
  edge_t  r03_r [3];
  plo_t   pl4_r [3];
  prod_t  ph4_r [3];
  adj_t   adj4_r [3][3];
  det_t   t5_r [3];
  adj_t   adj5_r [3][3];
  det_t   det6_r;
  adj_t   adj6_r [3][3];
  mag_t   num7_r [NDIV];
  mag_t   den7_r [NDIV];
  logic   neg7_r [NDIV];
  logic   zero7_r;
  mag_t   vsum7_r;
  logic   vneg7_r;
  logic [2*QB-1:0] vprod8_r;
  logic   vbig8_r;
  logic   vneg8_r;
  res_t   vol_d_r [DIV_LAT-1];
  res_t   vol_r;
  logic [DIV_LAT-1:0] sing_r;
  res_t   quo [NDIV];
  res_t   res_r [NDIV];
  logic   sing_out_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[VL-2:0], in_valid};
      out_valid_r <= v_r[VL-1];
    end
  end

  assign p[0][0] = in_v0_x;
  assign p[0][1] = in_v0_y;
  assign p[0][2] = in_v0_z;
  assign p[1][0] = in_v1_x;
  assign p[1][1] = in_v1_y;
  assign p[1][2] = in_v1_z;
  assign p[2][0] = in_v2_x;
  assign p[2][1] = in_v2_y;
  assign p[2][2] = in_v2_z;
  assign p[3][0] = in_v3_x;
  assign p[3][1] = in_v3_y;
  assign p[3][2] = in_v3_z;

  for (genvar r = 0; r < 3; r++) begin : g_edge
    for (genvar c = 0; c < 3; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) begin
          m1_r[r][c] <= edge_t'(p[c+1][r]) - edge_t'(p[0][r]);
        end
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_adj_row
    for (genvar j = 0; j < 3; j++) begin : g_adj_col
      localparam int I1 = (i + 1) % 3;
      localparam int I2 = (i + 2) % 3;
      localparam int J1 = (j + 1) % 3;
      localparam int J2 = (j + 2) % 3;
      always_ff @(posedge clk) begin
        if (en) begin
          pa2_r[i][j]  <= m1_r[J1][I1] * m1_r[J2][I2];
          pb2_r[i][j]  <= m1_r[J1][I2] * m1_r[J2][I1];
          adj3_r[i][j] <= adj_t'(pa2_r[i][j]) - adj_t'(pb2_r[i][j]);
          adj4_r[i][j] <= adj3_r[i][j];
          adj5_r[i][j] <= adj4_r[i][j];
          adj6_r[i][j] <= adj5_r[i][j];
        end
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_det
    always_ff @(posedge clk) begin
      if (en) begin
        r02_r[j] <= m1_r[0][j];
        r03_r[j] <= r02_r[j];
        pl4_r[j] <= r03_r[j] * $signed({1'b0, adj3_r[j][0][LO_B-1:0]});
        ph4_r[j] <= r03_r[j] * $signed(adj3_r[j][0][AW-1:LO_B]);
        t5_r[j]  <= (det_t'(ph4_r[j]) <<< LO_B) + det_t'(pl4_r[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det6_r <= t5_r[0] + t5_r[1] + t5_r[2];
    end
  end

  always_ff @(posedge clk) begin
    det_t abs_det;
    adj_t abs_adj;
    mag_t mdet;
    if (en) begin
      abs_det   = det6_r[DTW-1] ? -det6_r : det6_r;
      mdet      = NW'($unsigned(abs_det));
      vsum7_r   <= mdet + VOL_BIAS;
      vneg7_r   <= det6_r[DTW-1];
      zero7_r   <= (det6_r == '0);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          abs_adj = adj6_r[i][j][AW-1] ? -adj6_r[i][j] : adj6_r[i][j];
          num7_r[3*i + j] <= (NW'($unsigned(abs_adj)) << (2 * FRAC_BITS + 1)) + mdet;
          den7_r[3*i + j] <= mdet << 1;
          neg7_r[3*i + j] <= adj6_r[i][j][AW-1] ^ det6_r[DTW-1];
        end
      end
    end
  end

  // The shifted sum is divided by three with a reciprocal multiply; larger values saturate.
  always_ff @(posedge clk) begin
    mag_t vy;
    if (en) begin
      vy       = vsum7_r >> VOL_RSH;
      vbig8_r  <= (vy >= VOL_SAT);
      vneg8_r  <= vneg7_r;
      vprod8_r <= vy[QB-1:0] * VOL_RECIP;
    end
  end

  always_ff @(posedge clk) begin
    logic [OW-1:0] vq;
    if (en) begin
      vq = {1'b0, vprod8_r[VOL_SH +: OW-1]};
      if (vbig8_r) begin
        vol_d_r[0] <= vneg8_r ? OUT_MIN : OUT_MAX;
      end else begin
        vol_d_r[0] <= vneg8_r ? (~vq + OW'(1)) : vq;
      end
      for (int k = 1; k < DIV_LAT - 1; k++) begin
        vol_d_r[k] <= vol_d_r[k-1];
      end
    end
  end

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    trsi_div u_div (
      .clk (clk),
      .en  (en),
      .num (num7_r[k]),
      .den (den7_r[k]),
      .neg (neg7_r[k]),
      .quo (quo[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sing_r     <= {sing_r[DIV_LAT-2:0], zero7_r};
      sing_out_r <= sing_r[DIV_LAT-1];
      vol_r      <= vol_d_r[DIV_LAT-2];
      for (int k = 0; k < NDIV; k++) begin
        res_r[k] <= sing_r[DIV_LAT-1] ? '0 : quo[k];
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_volume   = vol_r;
  assign out_inv_r0c0 = res_r[0];
  assign out_inv_r0c1 = res_r[1];
  assign out_inv_r0c2 = res_r[2];
  assign out_inv_r1c0 = res_r[3];
  assign out_inv_r1c1 = res_r[4];
  assign out_inv_r1c2 = res_r[5];
  assign out_inv_r2c0 = res_r[6];
  assign out_inv_r2c1 = res_r[7];
  assign out_inv_r2c2 = res_r[8];
  assign out_singular = sing_out_r;

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("Valid pipeline moved during a stall.");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_r[0])
    else $error("Accepted transfer did not enter the pipeline.");
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_singular) |-> (out_inv_r0c0 == '0 && out_inv_r1c1 == '0
      && out_inv_r2c2 == '0 && out_inv_r0c2 == '0 && out_inv_r2c0 == '0))
    else $error("Singular result carries a nonzero inverse.");
  a_sing_vol: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_singular) |-> (out_volume == '0))
    else $error("Singular result carries a nonzero volume.");
`endif
endmodule
`default_nettype wire

// ===== hdl/trsi_div.sv =====
// Pipelined restoring divider with half-away rounding input and 32-bit saturation.
`default_nettype none
module trsi_div (
  input  logic                  clk,
  input  logic                  en,
  input  logic [trsi_pkg::NW-1:0] num,
  input  logic [trsi_pkg::NW-1:0] den,
  input  logic                  neg,
  output logic signed [trsi_pkg::OW-1:0] quo
);
  import trsi_pkg::*;

  localparam int RW = NW + QB;

  logic [RW-1:0] rem_r [QB+1];
  logic [NW-1:0] den_r [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic          neg_r [QB+1];
  logic          big_r [QB+1];
  logic [OW-1:0] quo_r;
  logic [OW-1:0] quo_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= RW'(num);
      den_r[0] <= den;
      q_r[0]   <= '0;
      neg_r[0] <= neg;
      big_r[0] <= (RW'(num) >= {den, {QB{1'b0}}});
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_stage
    localparam int K = QB - s;
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = RW'(den_r[s-1]) << K;
    assign ge    = rem_r[s-1] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? (rem_r[s-1] - trial) : rem_r[s-1];
        den_r[s] <= den_r[s-1];
        q_r[s]   <= {q_r[s-1][QB-2:0], ge};
        neg_r[s] <= neg_r[s-1];
        big_r[s] <= big_r[s-1];
      end
    end
  end

  always_comb begin
    if (neg_r[QB]) begin
      if (big_r[QB] || (q_r[QB] > NEG_LIM)) begin
        quo_nxt = OUT_MIN;
      end else begin
        quo_nxt = OW'(~q_r[QB] + QB'(1));
      end
    end else begin
      if (big_r[QB] || (q_r[QB] > POS_LIM)) begin
        quo_nxt = OUT_MAX;
      end else begin
        quo_nxt = OW'(q_r[QB]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo = $signed(quo_r);
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for the tetrahedron rest-shape inverse: directed table plus random tetrahedra.
module testbench;
  import trsi_pkg::*;

  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] CMIN = 32'sh8000_0000;
  localparam int N_RANDOM = 430;
  localparam int QUIET_AFTER = 360;
  localparam int IDLE_LIMIT = 4000;

  typedef struct {
    logic signed [31:0] vol;
    logic signed [31:0] inv[9];
    logic sing;
  } tet_res_t;

  typedef struct {
    logic signed [31:0] c[12];
    bit chk;
    tet_res_t res;
  } tet_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid, out_singular;
  logic signed [31:0] vin[12];
  logic signed [31:0] vout[10];

  tet_res_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_count = 0;
  bit long_hold = 1'b0;
  bit quiet = 1'b0;

  always #5 clk = ~clk;

  tet_rest_shape_inverse dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_v0_x(vin[0]), .in_v0_y(vin[1]), .in_v0_z(vin[2]),
    .in_v1_x(vin[3]), .in_v1_y(vin[4]), .in_v1_z(vin[5]),
    .in_v2_x(vin[6]), .in_v2_y(vin[7]), .in_v2_z(vin[8]),
    .in_v3_x(vin[9]), .in_v3_y(vin[10]), .in_v3_z(vin[11]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_volume(vout[0]),
    .out_inv_r0c0(vout[1]), .out_inv_r0c1(vout[2]), .out_inv_r0c2(vout[3]),
    .out_inv_r1c0(vout[4]), .out_inv_r1c1(vout[5]), .out_inv_r1c2(vout[6]),
    .out_inv_r2c0(vout[7]), .out_inv_r2c1(vout[8]), .out_inv_r2c2(vout[9]),
    .out_singular(out_singular)
  );

  function automatic logic signed [31:0] round_sat_div(logic signed [255:0] n,
                                                        logic signed [255:0] d);
    logic signed [255:0] an, ad, q;
    bit neg;
    neg = (n < 0) != (d < 0);
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q = (2 * an + ad) / (2 * ad);
    if (neg) return (q > 256'sd2147483648) ? OUT_MIN : 32'(-q);
    return (q > 256'sd2147483647) ? OUT_MAX : 32'(q);
  endfunction

  function automatic tet_res_t invert_edges(logic signed [31:0] c[12]);
    logic signed [255:0] m[3][3], adj[3][3], det, p0, p1;
    tet_res_t r;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) begin
        p0 = c[i];
        p1 = c[(k + 1) * 3 + i];
        m[i][k] = p1 - p0;
      end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        adj[i][j] = m[(j + 1) % 3][(i + 1) % 3] * m[(j + 2) % 3][(i + 2) % 3]
                  - m[(j + 1) % 3][(i + 2) % 3] * m[(j + 2) % 3][(i + 1) % 3];
    det = 0;
    for (int j = 0; j < 3; j++) det += m[0][j] * adj[j][0];
    r.vol = round_sat_div(det, 256'sd6 <<< (2 * FRAC_BITS));
    r.sing = (det == 0);
    for (int i = 0; i < 9; i++)
      r.inv[i] = r.sing ? 32'sd0
               : round_sat_div(adj[i / 3][i % 3] <<< (2 * FRAC_BITS), det);
    return r;
  endfunction

  function automatic tet_res_t make_result(logic signed [31:0] vol, logic signed [31:0] d,
                                           logic signed [31:0] off, logic sing);
    tet_res_t r;
    r.vol = vol;
    r.sing = sing;
    for (int i = 0; i < 9; i++) r.inv[i] = (i % 4 == 0) ? d : off;
    return r;
  endfunction

  task automatic report(string field, logic signed [31:0] got, logic signed [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
    errors++;
  endtask

  task automatic send_tet(logic signed [31:0] c[12]);
    bit ok;
    in_valid <= 1'b1;
    for (int i = 0; i < 12; i++) vin[i] <= c[i];
    ok = 1'b0;
    while (!ok) begin
      @(negedge clk);
      ok = in_ready;
      @(posedge clk);
    end
    expected_q.push_back(invert_edges(c));
  endtask

  task automatic idle_sender();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] rand_coord(int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
      default: return $signed($urandom_range(0, 512)) - 256;
    endcase
  endfunction

  always @(negedge clk) begin
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL tet_rest_shape_inverse");
      $finish;
    end
  end

  initial begin
    tet_res_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("unexpected transfer at output, time %0t", $time);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (vout[0] !== want.vol) report("volume", vout[0], want.vol);
          for (int i = 0; i < 9; i++)
            if (vout[i + 1] !== want.inv[i])
              report($sformatf("inv_r%0dc%0d", i / 3, i % 3), vout[i + 1], want.inv[i]);
          if (out_singular !== want.sing) report("singular", out_singular, want.sing);
        end
      end
      @(posedge clk);
      if (hold_count > 0) begin
        hold_count--;
        out_ready <= 1'b0;
      end else if (long_hold) begin
        long_hold = 1'b0;
        hold_count = 100;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold_count = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    tet_row_t rows[$];
    tet_row_t row;
    logic signed [31:0] c[12];
    int kind;
    for (int i = 0; i < 12; i++) vin[i] = '0;

    row.chk = 1'b1;
    row.c = '{default: 0};
    row.res = make_result(0, 0, 0, 1'b1);
    rows.push_back(row);
    row.c = '{0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
    row.res = make_result(32'sd10923, ONE, 0, 1'b0);
    rows.push_back(row);
    row.c = '{0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, 2 * ONE};
    row.res = make_result(32'sd87381, 32'sd32768, 0, 1'b0);
    rows.push_back(row);
    row.c = '{default: CMAX};
    row.res = make_result(0, 0, 0, 1'b1);
    rows.push_back(row);
    row.c = '{default: CMIN};
    rows.push_back(row);
    row.c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1};
    row.res = make_result(0, OUT_MAX, 0, 1'b0);
    rows.push_back(row);
    row.c = '{0, 0, 0, 0, ONE, 0, ONE, 0, 0, 0, 0, ONE};
    row.res = make_result(-32'sd10923, 0, 0, 1'b0);
    row.res.inv[1] = ONE;
    row.res.inv[3] = ONE;
    row.res.inv[8] = ONE;
    rows.push_back(row);
    row.chk = 1'b0;
    row.c = '{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX};
    rows.push_back(row);
    row.c = '{CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN};
    rows.push_back(row);
    row.c = '{0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0, 1};
    rows.push_back(row);
    row.c = '{ONE, -ONE, 3, CMAX, 0, -7, 5, CMIN, ONE, -1, 2, CMAX};
    rows.push_back(row);
    row.c = '{0, 0, 0, 3 * ONE, 0, 0, 0, 3 * ONE, 0, 0, 0, 3 * ONE};
    rows.push_back(row);
    row.c = '{0, 0, 0, ONE, ONE, 0, 2 * ONE, 2 * ONE, 0, 0, 0, ONE};
    rows.push_back(row);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[k]) begin
      send_tet(rows[k].c);
      if (rows[k].chk) expected_q[expected_q.size() - 1] = rows[k].res;
      idle_sender();
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 100) long_hold = 1'b1;
      if (n == 250) begin
        in_valid <= 1'b0;
        wait (expected_q.size() == 0);
        @(posedge clk);
      end
      if (n == QUIET_AFTER) quiet = 1'b1;
      kind = $urandom_range(0, 2);
      for (int i = 0; i < 12; i++) c[i] = rand_coord(kind);
      case ($urandom_range(0, 9))
        0: for (int i = 0; i < 3; i++) c[9 + i] = c[3 + i];
        1: for (int i = 0; i < 3; i++) c[6 + i] = c[i];
        2: for (int i = 0; i < 3; i++) c[9 + i] = c[3 + i] + c[6 + i] - c[i];
        default: ;
      endcase
      send_tet(c);
      idle_sender();
    end
    in_valid <= 1'b0;

    wait (expected_q.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("PASS tet_rest_shape_inverse");
    else $display("FAIL tet_rest_shape_inverse");
    $finish;
  end
endmodule
